// ----- rtl/min_spanning_tree_weight_top_macros.svh -----
`ifndef MIN_SPANNING_TREE_WEIGHT_TOP_MACROS_SVH
`define MIN_SPANNING_TREE_WEIGHT_TOP_MACROS_SVH

// Assertion helpers for the block that checks itself.
`define MSTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MSTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mstw_pkg.sv -----
`default_nettype none
package mstw_pkg;

    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int OUT_BITS        = 22;
    localparam int OUT_HI          = 2097151;
    localparam int OUT_LO          = -2097152;

    typedef struct packed {
        logic clear_wr;
        logic edge_rd;
        logic edge_wr;
        logic init;
        logic relax;
        logic pick_en;
        logic epoch;
    } mstw_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/mstw_cell.sv -----
`default_nettype none
module mstw_cell #(
    parameter int MAX_NODES   = mstw_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = mstw_pkg::DEF_WEIGHT_BITS,
    parameter int NODE_BITS   = $clog2(mstw_pkg::DEF_MAX_NODES),
    parameter int IDX         = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mstw_pkg::mstw_ctl_t           ctl,
    input  logic [NODE_BITS-1:0]          node_a,
    input  logic [NODE_BITS-1:0]          node_b,
    input  logic [NODE_BITS-1:0]          addr,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    input  logic                          prev_found,
    input  logic signed [WEIGHT_BITS-1:0] prev_w,
    input  logic [NODE_BITS-1:0]          prev_idx,
    output logic                          next_found,
    output logic signed [WEIGHT_BITS-1:0] next_w,
    output logic [NODE_BITS-1:0]          next_idx
);
    import mstw_pkg::*;

    localparam logic [NODE_BITS-1:0] MY_IDX = NODE_BITS'(IDX);

    // Column IDX of the adjacency matrix: present bit, epoch bit, weight.
    logic [WEIGHT_BITS+1:0] mem [MAX_NODES];
    logic [WEIGHT_BITS+1:0] rdata_reg;

    logic                          visited_reg, visited_next;
    logic                          best_pres_reg, best_pres_next;
    logic signed [WEIGHT_BITS-1:0] best_w_reg, best_w_next;
    logic                          link_found_reg, link_found_next;
    logic signed [WEIGHT_BITS-1:0] link_w_reg, link_w_next;
    logic [NODE_BITS-1:0]          link_idx_reg, link_idx_next;

    logic [NODE_BITS-1:0]          rd_addr;
    logic [NODE_BITS-1:0]          wr_addr;
    logic [WEIGHT_BITS+1:0]        wr_data;
    logic                          wr_en;
    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic                          entry_ok;
    logic                          hit;
    logic                          relax_upd;
    logic                          cand;

    assign rd_w     = rdata_reg[WEIGHT_BITS-1:0];
    assign entry_ok = rdata_reg[WEIGHT_BITS+1] && (rdata_reg[WEIGHT_BITS] == ctl.epoch);
    assign hit      = (MY_IDX == node_a) || (MY_IDX == node_b);
    assign rd_addr  = ctl.edge_rd ? ((MY_IDX == node_b) ? node_a : node_b) : addr;

    always_comb
    begin
        if (ctl.clear_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = addr;
            wr_data = '0;
        end
        else
        begin
            wr_en   = ctl.edge_wr && hit && (!entry_ok || (weight < rd_w));
            wr_addr = (MY_IDX == node_a) ? node_b : node_a;
            wr_data = {1'b1, ctl.epoch, weight};
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign relax_upd = ctl.relax && !visited_reg && entry_ok
                       && (!best_pres_reg || (rd_w < best_w_reg));
    assign cand      = !visited_reg && best_pres_reg;

    always_comb
    begin
        visited_next   = visited_reg;
        best_pres_next = best_pres_reg;
        best_w_next    = best_w_reg;
        if (ctl.init)
        begin
            visited_next   = (MY_IDX == '0);
            best_pres_next = 1'b0;
        end
        else if (ctl.pick_en && (addr == MY_IDX))
        begin
            visited_next = 1'b1;
        end
        else if (relax_upd)
        begin
            best_pres_next = 1'b1;
            best_w_next    = rd_w;
        end

        // A tie keeps the lower-numbered node coming down the chain.
        if (cand && (!prev_found || (best_w_reg < prev_w)))
        begin
            link_found_next = 1'b1;
            link_w_next     = best_w_reg;
            link_idx_next   = MY_IDX;
        end
        else
        begin
            link_found_next = prev_found;
            link_w_next     = prev_w;
            link_idx_next   = prev_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg    <= 1'b0;
            best_pres_reg  <= 1'b0;
            link_found_reg <= 1'b0;
        end
        else
        begin
            visited_reg    <= visited_next;
            best_pres_reg  <= best_pres_next;
            link_found_reg <= link_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_w_reg   <= best_w_next;
        link_w_reg   <= link_w_next;
        link_idx_reg <= link_idx_next;
    end

    assign next_found = link_found_reg;
    assign next_w     = link_w_reg;
    assign next_idx   = link_idx_reg;

endmodule
`default_nettype wire

// ----- rtl/min_spanning_tree_weight_top.sv -----
// Minimum spanning tree weight by Prim's algorithm over a chain of MAX_NODES node cells.
// Each input word is one undirected edge; its adjacency entry is read in ST_IDLE and
// rewritten in ST_EDGE, if empty or heavier, in the column memories of its two end
// cells. The word flagged last_edge then starts tree growth from node 0: each node
// added takes a relax step, a scan down the minimum-search chain and a pick, and
// tree_weight comes out as the one result word once no further node can be added.
// After that word is issued, a clearing pass empties the adjacency store while the
// input is stalled; the same pass runs after reset before the first edge is accepted.
// Sums beyond 22 bits saturate.
`default_nettype none
`include "min_spanning_tree_weight_top_macros.svh"
module min_spanning_tree_weight_top #(
    parameter int MAX_NODES   = mstw_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = mstw_pkg::DEF_WEIGHT_BITS,
    parameter int NODE_BITS   = $clog2(MAX_NODES)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [NODE_BITS-1:0]                    node_a,
    input  logic [NODE_BITS-1:0]                    node_b,
    input  logic signed [WEIGHT_BITS-1:0]           edge_weight,
    input  logic                                    last_edge,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [mstw_pkg::OUT_BITS-1:0]    tree_weight
);
    import mstw_pkg::*;

    localparam int SUM_BITS = WEIGHT_BITS + NODE_BITS + 1;
    localparam int ACC_BITS = (SUM_BITS > OUT_BITS + 1) ? SUM_BITS : OUT_BITS + 1;
    localparam int CNT_BITS = $clog2(MAX_NODES + 2);
    localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(OUT_HI);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(OUT_LO);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EDGE   = 3'd2;
    localparam logic [2:0] ST_INIT   = 3'd3;
    localparam logic [2:0] ST_RELAX  = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_PICK   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic                          epoch_reg, epoch_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0]    tree_weight_reg, tree_weight_next;
    logic signed [ACC_BITS-1:0]    total_reg, total_next;
    logic [NODE_BITS-1:0]          a_reg, a_next;
    logic [NODE_BITS-1:0]          b_reg, b_next;
    logic signed [WEIGHT_BITS-1:0] w_reg, w_next;
    logic                          last_reg, last_next;

    mstw_ctl_t                     ctl;
    logic [NODE_BITS-1:0]          cell_a;
    logic [NODE_BITS-1:0]          cell_b;
    logic [NODE_BITS-1:0]          cell_addr;
    logic                          accept;
    logic                          edge_ok;
    logic signed [ACC_BITS-1:0]    sat;

    logic                          link_found [MAX_NODES+1];
    logic signed [WEIGHT_BITS-1:0] link_w     [MAX_NODES+1];
    logic [NODE_BITS-1:0]          link_idx   [MAX_NODES+1];

    assign link_found[0] = 1'b0;
    assign link_w[0]     = '0;
    assign link_idx[0]   = '0;

    for (genvar k = 0; k < MAX_NODES; k++)
    begin : g_cell
        mstw_cell #(
            .MAX_NODES   (MAX_NODES),
            .WEIGHT_BITS (WEIGHT_BITS),
            .NODE_BITS   (NODE_BITS),
            .IDX         (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .node_a     (cell_a),
            .node_b     (cell_b),
            .addr       (cell_addr),
            .weight     (w_reg),
            .prev_found (link_found[k]),
            .prev_w     (link_w[k]),
            .prev_idx   (link_idx[k]),
            .next_found (link_found[k+1]),
            .next_w     (link_w[k+1]),
            .next_idx   (link_idx[k+1])
        );
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign edge_ok  = ({1'b0, a_reg} < (NODE_BITS+1)'(MAX_NODES))
                      && ({1'b0, b_reg} < (NODE_BITS+1)'(MAX_NODES))
                      && (a_reg != b_reg);
    assign cell_a   = (state_reg == ST_IDLE) ? node_a : a_reg;
    assign cell_b   = (state_reg == ST_IDLE) ? node_b : b_reg;

    always_comb
    begin
        if (total_reg > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (total_reg < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = total_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        epoch_next       = epoch_reg;
        out_valid_next   = out_valid_reg && out_stall;
        tree_weight_next = tree_weight_reg;
        total_next       = total_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        w_next           = w_reg;
        last_next        = last_reg;
        ctl              = '0;
        ctl.epoch        = epoch_reg;
        cell_addr        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                cell_addr    = cnt_reg[NODE_BITS-1:0];
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ctl.edge_rd = 1'b1;
                if (accept)
                begin
                    a_next     = node_a;
                    b_next     = node_b;
                    w_next     = edge_weight;
                    last_next  = last_edge;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                ctl.edge_wr = edge_ok;
                state_next  = last_reg ? ST_INIT : ST_IDLE;
            end
            ST_INIT:
            begin
                ctl.init   = 1'b1;
                total_next = '0;
                state_next = ST_RELAX;
            end
            ST_RELAX:
            begin
                ctl.relax  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MAX_NODES))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cell_addr = link_idx[MAX_NODES];
                if (link_found[MAX_NODES])
                begin
                    ctl.pick_en = 1'b1;
                    total_next  = total_reg + ACC_BITS'(link_w[MAX_NODES]);
                    state_next  = ST_RELAX;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next   = 1'b1;
                    tree_weight_next = sat[OUT_BITS-1:0];
                    epoch_next       = !epoch_reg;
                    cnt_next         = '0;
                    state_next       = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            epoch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tree_weight_reg <= tree_weight_next;
        total_reg       <= total_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        w_reg           <= w_next;
    end

    assign out_valid   = out_valid_reg;
    assign tree_weight = tree_weight_reg;

    `MSTW_ASSERT_NEXT(a_accept_edge, clk, rst_n, accept, state_reg == ST_EDGE, "edge not stored")
    `MSTW_ASSERT_NOW(a_out_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FINISH, "result outside finish")
    `MSTW_ASSERT_NEXT(a_pick_done, clk, rst_n, (state_reg == ST_PICK) && !link_found[MAX_NODES], state_reg == ST_FINISH, "tree growth did not end")

endmodule
`default_nettype wire
